/* sv/wfpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_pkg
// Shared types and constants for the worst-fit partition allocator.
// ----------------------------------------------------------------------------
package wfpa_pkg;

  // Table geometry
  localparam int SLOTS     = 16;
  localparam int SIZE_BITS = 16;
  localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_BITS  = $clog2(SLOTS + 1);

  // Fixed field widths of the channel words
  localparam int CFG_BITS  = 5;
  localparam int IDX_W     = 4;
  localparam int SZ_W      = 16;
  localparam int STAT_W    = 2;

  // Action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_LOADED    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ALLOCATED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOFIT     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_UNUSED    = 2'd3;

  typedef struct packed {
    logic             action;
    logic [IDX_W-1:0] slot_index;
    logic [SZ_W-1:0]  size_value;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  chosen_slot;
    logic [SZ_W-1:0]   remaining_size;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

endpackage

/* sv/wfpa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wfpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/worst_fit_partition_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator
// Free-size table with worst-fit search; one result word per input word.
// ----------------------------------------------------------------------------
// Sequencing: a load word is written in IDLE and passes through FINISH to
//   the output register; an allocate word runs SCAN, DECIDE and FINISH,
//   scanning N entries, N = partitions in use clamped to SLOTS.
// Throughput: one word at a time; the scan reads one table entry per cycle
//   from the single RAM read port, and FINISH holds through any output stall.
// Reset (rst_n low, synchronous): table reads as all zero at once through
//   per-slot valid flags, partitions_in_use = 0, output empty.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration: partitions_in_use
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wfpa_pkg::CFG_BITS-1:0] cfg_data,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wfpa_pkg::in_word_t            in_word,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output wfpa_pkg::out_word_t           out_word
);

  localparam int SB = wfpa_pkg::SIZE_BITS;
  localparam int AB = wfpa_pkg::SLOT_BITS;
  localparam int CB = wfpa_pkg::CNT_BITS;

  // control
  wfpa_pkg::state_t state_r, state_nxt;
  logic [wfpa_pkg::CFG_BITS-1:0] pin_r, pin_nxt;       // partitions_in_use
  logic [wfpa_pkg::SLOTS-1:0]    vld_r, vld_nxt;       // slot written since reset
  logic [CB-1:0]                 cnt_r, cnt_nxt;       // clamped scan length
  logic [CB-1:0]                 rd_idx_r, rd_idx_nxt; // next address to read
  logic                          rd_pend_r, rd_pend_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // datapath
  logic [AB-1:0]          rd_slot_r, rd_slot_nxt;
  logic                   vld_d_r, vld_d_nxt;
  logic [SB-1:0]          size_r, size_nxt;
  logic                   found_r, found_nxt;
  logic [AB-1:0]          best_slot_r, best_slot_nxt;
  logic [SB-1:0]          best_val_r, best_val_nxt;
  wfpa_pkg::out_word_t    res_r, res_nxt;
  wfpa_pkg::out_word_t    out_r, out_nxt;

  // RAM port
  logic          ram_we;
  logic [AB-1:0] ram_waddr;
  logic [SB-1:0] ram_wdata;
  logic [AB-1:0] ram_raddr;
  logic [SB-1:0] ram_rdata;

  // scratch
  logic          issue;
  logic [SB-1:0] cur_val;
  logic [SB-1:0] in_size;
  logic [SB-1:0] diff;
  logic          slot_ok;

  wfpa_ram #(
    .WIDTH (SB),
    .DEPTH (wfpa_pkg::SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == wfpa_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Entries never written since reset read as zero
  assign cur_val = vld_d_r ? ram_rdata : '0;
  // Request reduced to the table width
  assign in_size = SB'(in_word.size_value);
  assign diff    = best_val_r - size_r;
  assign slot_ok = (32'(in_word.slot_index) < 32'(wfpa_pkg::SLOTS));

  always_comb begin
    state_nxt     = state_r;
    pin_nxt       = pin_r;
    vld_nxt       = vld_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    rd_pend_nxt   = rd_pend_r;
    rd_slot_nxt   = rd_slot_r;
    vld_d_nxt     = vld_d_r;
    size_nxt      = size_r;
    found_nxt     = found_r;
    best_slot_nxt = best_slot_r;
    best_val_nxt  = best_val_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = rd_idx_r[AB-1:0];
    issue         = 1'b0;

    if (cfg_valid) begin
      pin_nxt = cfg_data;
    end

    // output register drains independently of the engine
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      wfpa_pkg::ST_IDLE: begin
        if (in_valid) begin
          size_nxt = in_size;
          if (in_word.action == wfpa_pkg::ACT_LOAD) begin
            // load: write straight into the table
            res_nxt.status      = wfpa_pkg::STAT_LOADED;
            res_nxt.chosen_slot = in_word.slot_index;
            if (slot_ok) begin
              ram_we                      = 1'b1;
              ram_waddr                   = AB'(in_word.slot_index);
              ram_wdata                   = in_size;
              vld_nxt[AB'(in_word.slot_index)] = 1'b1;
              res_nxt.remaining_size      = wfpa_pkg::SZ_W'(in_size);
            end else begin
              res_nxt.remaining_size = '0;
            end
            state_nxt = wfpa_pkg::ST_FINISH;
          end else begin
            // allocate: clamp the slot count, start the scan at slot 0
            if (32'(pin_r) > 32'(wfpa_pkg::SLOTS)) begin
              cnt_nxt = CB'(wfpa_pkg::SLOTS);
            end else begin
              cnt_nxt = CB'(pin_r);
            end
            rd_idx_nxt    = '0;
            rd_pend_nxt   = 1'b0;
            found_nxt     = 1'b0;
            best_slot_nxt = '0;
            best_val_nxt  = '0;
            state_nxt     = wfpa_pkg::ST_SCAN;
          end
        end
      end

      wfpa_pkg::ST_SCAN: begin
        // read one entry per cycle; compare the previous cycle's read
        issue       = (rd_idx_r < cnt_r);
        rd_pend_nxt = issue;
        rd_slot_nxt = rd_idx_r[AB-1:0];
        vld_d_nxt   = vld_r[rd_idx_r[AB-1:0]];
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (rd_pend_r) begin
          // strict compare keeps the lowest index on ties
          if ((cur_val >= size_r) && (!found_r || (best_val_r < cur_val))) begin
            found_nxt     = 1'b1;
            best_slot_nxt = rd_slot_r;
            best_val_nxt  = cur_val;
          end
        end
        if (!issue && !rd_pend_r) begin
          state_nxt = wfpa_pkg::ST_DECIDE;
        end
      end

      wfpa_pkg::ST_DECIDE: begin
        if (found_r) begin
          ram_we                 = 1'b1;
          ram_waddr              = best_slot_r;
          ram_wdata              = diff;
          vld_nxt[best_slot_r]   = 1'b1;
          res_nxt.status         = wfpa_pkg::STAT_ALLOCATED;
          res_nxt.chosen_slot    = wfpa_pkg::IDX_W'(best_slot_r);
          res_nxt.remaining_size = wfpa_pkg::SZ_W'(diff);
        end else begin
          res_nxt.status         = wfpa_pkg::STAT_NOFIT;
          res_nxt.chosen_slot    = '0;
          res_nxt.remaining_size = '0;
        end
        state_nxt = wfpa_pkg::ST_FINISH;
      end

      wfpa_pkg::ST_FINISH: begin
        // hand over once the output register is free or draining
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = wfpa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = wfpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wfpa_pkg::ST_IDLE;
      pin_r       <= '0;
      vld_r       <= '0;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pin_r       <= pin_nxt;
      vld_r       <= vld_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r   <= rd_slot_nxt;
    vld_d_r     <= vld_d_nxt;
    size_r      <= size_nxt;
    best_slot_r <= best_slot_nxt;
    best_val_r  <= best_val_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

endmodule

/* sv/wfpa_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_chk
// Port-level checks for the worst-fit partition allocator.
// ----------------------------------------------------------------------------
module wfpa_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  wfpa_pkg::out_word_t           out_word
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // one word in flight: engine is busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.status != wfpa_pkg::STAT_UNUSED)
    else $error("undefined status code");

  a_nofit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == wfpa_pkg::STAT_NOFIT |->
      out_word.chosen_slot == '0 && out_word.remaining_size == '0)
    else $error("no-fit word carries slot or size");

  // a new result only appears after an input was taken
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_ready || $past(!in_ready))
    else $error("result without work");

endmodule

bind worst_fit_partition_allocator wfpa_chk u_wfpa_chk (.*);

/* tb/wfpa_alloc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_alloc_checker
// Watches the config, request and result channels of the allocator. Keeps its
// own free-size table, works out each result word on request acceptance and
// checks result words in order, field by field.
// ----------------------------------------------------------------------------
module wfpa_alloc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [wfpa_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  wfpa_pkg::in_word_t            in_word,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  wfpa_pkg::out_word_t           out_word,
  output int                            fail_count,
  output int                            outstanding,
  output int                            fit_count,
  output int                            nofit_count
);

  logic [wfpa_pkg::SIZE_BITS-1:0] free_size [wfpa_pkg::SLOTS];
  logic [wfpa_pkg::CFG_BITS-1:0]  span_cfg;
  wfpa_pkg::out_word_t            slot_outcomes [$];

  // Applies one request word to the local table and returns its result word.
  function automatic wfpa_pkg::out_word_t serve_request(input wfpa_pkg::in_word_t w);
    wfpa_pkg::out_word_t           r;
    int                            span;
    logic [wfpa_pkg::IDX_W-1:0]    best;
    bit                            found;
    r     = '0;
    best  = '0;
    found = 1'b0;
    span  = (span_cfg > wfpa_pkg::SLOTS) ? wfpa_pkg::SLOTS : int'(span_cfg);
    if (w.action == wfpa_pkg::ACT_LOAD) begin
      r.status      = wfpa_pkg::STAT_LOADED;
      r.chosen_slot = w.slot_index;
      if (w.slot_index < wfpa_pkg::SLOTS) begin
        free_size[w.slot_index] = w.size_value;
        r.remaining_size        = w.size_value;
      end
    end else begin
      // largest entry that still covers the request, lowest index on ties
      for (int j = 0; j < span; j++) begin
        if (free_size[wfpa_pkg::IDX_W'(j)] >= w.size_value &&
            (!found || free_size[wfpa_pkg::IDX_W'(j)] > free_size[best])) begin
          best  = wfpa_pkg::IDX_W'(j);
          found = 1'b1;
        end
      end
      if (found) begin
        free_size[best]  = free_size[best] - w.size_value;
        r.status         = wfpa_pkg::STAT_ALLOCATED;
        r.chosen_slot    = best;
        r.remaining_size = free_size[best];
      end else begin
        r.status = wfpa_pkg::STAT_NOFIT;
      end
    end
    return r;
  endfunction

  task automatic report_fault(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] checker: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin : watch
    wfpa_pkg::out_word_t want;
    if (!rst_n) begin
      foreach (free_size[i]) free_size[i] = '0;
      span_cfg = '0;
      slot_outcomes.delete();
      fail_count  = 0;
      fit_count   = 0;
      nofit_count = 0;
      outstanding = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (slot_outcomes.size() == 0) begin
          report_fault($sformatf("result word with none pending: status %0d slot %0d rem %0d",
                                 out_word.status, out_word.chosen_slot,
                                 out_word.remaining_size));
        end else begin
          want = slot_outcomes.pop_front();
          if (out_word.status !== want.status ||
              out_word.chosen_slot !== want.chosen_slot ||
              out_word.remaining_size !== want.remaining_size) begin
            report_fault($sformatf({"mismatch: expected status %0d slot %0d rem %0d, ",
                                    "got status %0d slot %0d rem %0d"},
                                   want.status, want.chosen_slot, want.remaining_size,
                                   out_word.status, out_word.chosen_slot,
                                   out_word.remaining_size));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        span_cfg = cfg_data;
      end
      if (in_valid && in_ready) begin
        want = serve_request(in_word);
        if (want.status == wfpa_pkg::STAT_ALLOCATED) fit_count++;
        if (want.status == wfpa_pkg::STAT_NOFIT) nofit_count++;
        slot_outcomes.push_back(want);
      end
      outstanding = slot_outcomes.size();
    end
  end

endmodule

/* tb/tb_worst_fit_partition_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_worst_fit_partition_allocator
// Regression for the worst-fit partition allocator: a directed pass over the
// corner cases, then randomized load/allocate traffic under several table
// spans, with bursty requests and a stalling result consumer. Checking lives
// in wfpa_alloc_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_worst_fit_partition_allocator;

  // Result-side stall styles, each held for a random stretch before the next.
  typedef enum int {
    DRAIN_FREE,   // always ready
    DRAIN_LIGHT,  // randomly ready, with odds of three to one
    DRAIN_HEAVY,  // randomly ready, with odds of one in four
    DRAIN_HOLD    // long hold-offs broken by single ready cycles
  } drain_mode_t;

  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 88;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [wfpa_pkg::CFG_BITS-1:0] cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  wfpa_pkg::in_word_t            in_word;
  logic                          out_valid;
  logic                          out_ready;
  wfpa_pkg::out_word_t           out_word;

  int fail_count;
  int outstanding;
  int fit_count;
  int nofit_count;
  int words_sent;
  int span_writes;

  // Last size loaded per slot; lets some requests aim for an exact fit.
  logic [wfpa_pkg::SZ_W-1:0] last_load [wfpa_pkg::SLOTS];

  worst_fit_partition_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  wfpa_alloc_checker watcher (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .fit_count   (fit_count),
    .nofit_count (nofit_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop. The slowest legal run (every allocate scanning 16 slots, every
  // result held off by the longest stall, every gap at its longest) is well
  // within this limit, with a wide margin.
  initial begin
    #5_000_000;
    $display("timeout with %0d result words still pending", outstanding);
    $display("worst_fit_partition_allocator regression: fail");
    $finish;
  end

  // Result consumer: changes out_ready at the falling edge only.
  initial begin : drain
    drain_mode_t mode;
    int          left;
    out_ready = 1'b0;
    forever begin
      mode = drain_mode_t'($urandom_range(0, 3));
      left = $urandom_range(30, 150);
      while (left > 0) begin
        @(negedge clk);
        case (mode)
          DRAIN_FREE:  out_ready <= 1'b1;
          DRAIN_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
          DRAIN_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
          default: begin
            // hold off for a while, then open for exactly one cycle
            out_ready <= 1'b0;
            repeat ($urandom_range(4, 15)) @(negedge clk);
            out_ready <= 1'b1;
          end
        endcase
        left--;
      end
    end
  end

  // Presents one request word at a falling edge and returns at the falling
  // edge after it was taken. Valid is left high so that a following word
  // goes out back to back; the caller drops it for a gap.
  task automatic send_word(input wfpa_pkg::in_word_t w);
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic put(input logic act, input int slot, input int size);
    wfpa_pkg::in_word_t w;
    w.action     = act;
    w.slot_index = wfpa_pkg::IDX_W'(slot);
    w.size_value = wfpa_pkg::SZ_W'(size);
    send_word(w);
  endtask

  // Writes partitions_in_use once the block has drained: every request word
  // yields exactly one result, so nothing pending means the block is idle.
  task automatic set_span(input logic [wfpa_pkg::CFG_BITS-1:0] span);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_data  <= span;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    span_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random request word. Loads refill the table with mostly roomy sizes;
  // allocates lean toward requests that fit so the search stays busy, with
  // exact fits, zero requests, full-range and maximum requests mixed in.
  function automatic wfpa_pkg::in_word_t random_word();
    wfpa_pkg::in_word_t w;
    int                 pick;
    w.slot_index = wfpa_pkg::IDX_W'($urandom_range(0, wfpa_pkg::SLOTS - 1));
    pick         = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 35) begin
      w.action = wfpa_pkg::ACT_LOAD;
      if (pick < 10)      w.size_value = '0;
      else if (pick < 20) w.size_value = '1;
      else if (pick < 40) w.size_value = wfpa_pkg::SZ_W'($urandom_range(0, 255));
      else                w.size_value = wfpa_pkg::SZ_W'($urandom_range(0, 65535));
      last_load[w.slot_index] = w.size_value;
    end else begin
      w.action = wfpa_pkg::ACT_ALLOC;
      if (pick < 5)       w.size_value = '0;
      else if (pick < 10) w.size_value = '1;
      else if (pick < 50) w.size_value = wfpa_pkg::SZ_W'($urandom_range(0, 1023));
      else if (pick < 75) w.size_value = wfpa_pkg::SZ_W'($urandom_range(0, 65535));
      else w.size_value = last_load[wfpa_pkg::IDX_W'($urandom_range(0, wfpa_pkg::SLOTS - 1))];
    end
    return w;
  endfunction

  initial begin : stimulus
    logic [wfpa_pkg::CFG_BITS-1:0] span_plan [PHASES];
    int                            sent;
    int                            burst;
    int                            gap;

    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_word     = '0;
    words_sent  = 0;
    span_writes = 0;
    foreach (last_load[i]) last_load[i] = '0;

    // Spans: none, one, exactly all, over-range (clamped), and random ones below and above SLOTS.
    span_plan[0] = 5'd0;
    span_plan[1] = 5'd1;
    span_plan[2] = 5'd16;
    span_plan[3] = 5'd31;
    span_plan[4] = wfpa_pkg::CFG_BITS'($urandom_range(2, 15));
    span_plan[5] = wfpa_pkg::CFG_BITS'($urandom_range(17, 30));
    span_plan[6] = wfpa_pkg::CFG_BITS'($urandom_range(2, 15));
    span_plan[7] = 5'd16;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed ----
    // Out of reset no partition is in use: any allocate misses.
    put(wfpa_pkg::ACT_ALLOC, 15, 0);
    put(wfpa_pkg::ACT_LOAD, 0, 100);
    put(wfpa_pkg::ACT_LOAD, 5, 65535);
    put(wfpa_pkg::ACT_LOAD, 10, 65535);   // ties slot 5
    put(wfpa_pkg::ACT_LOAD, 3, 1);
    put(wfpa_pkg::ACT_LOAD, 15, 0);
    put(wfpa_pkg::ACT_ALLOC, 0, 5);       // still nothing in use
    set_span(5'd16);
    put(wfpa_pkg::ACT_ALLOC, 7, 0);       // zero request takes the largest, lowest on tie
    put(wfpa_pkg::ACT_ALLOC, 0, 65535);   // empties slot 5
    put(wfpa_pkg::ACT_ALLOC, 0, 65535);   // then slot 10
    put(wfpa_pkg::ACT_ALLOC, 0, 65535);   // nothing that large left
    put(wfpa_pkg::ACT_ALLOC, 0, 100);     // exact fit leaves zero
    put(wfpa_pkg::ACT_ALLOC, 0, 2);       // only slot 3 has anything, and too little
    put(wfpa_pkg::ACT_ALLOC, 0, 1);
    put(wfpa_pkg::ACT_ALLOC, 0, 0);       // all-zero table: zero request still fits
    put(wfpa_pkg::ACT_LOAD, 12, 16'hAAAA);
    put(wfpa_pkg::ACT_LOAD, 7, 16'h5555);
    put(wfpa_pkg::ACT_ALLOC, 9, 16'h5555);  // slot 12 drops to tie with slot 7
    put(wfpa_pkg::ACT_ALLOC, 9, 16'h0010);  // tie resolves to slot 7
    set_span(5'd31);            // above SLOTS, treated as all slots
    put(wfpa_pkg::ACT_ALLOC, 4, 0);
    set_span(5'd8);             // slot 12 now out of reach
    put(wfpa_pkg::ACT_ALLOC, 2, 16'h5545);
    put(wfpa_pkg::ACT_ALLOC, 2, 16'h0001);

    // ---- random phases ----
    for (int p = 0; p < PHASES; p++) begin
      set_span(span_plan[p]);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < PHASE_WORDS; k++) begin
          send_word(random_word());
          sent++;
        end
        // roughly one burst in four runs straight into the next
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end

    // ---- drain ----
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    // past the longest allocate latency, to catch any stray result word
    repeat (40) @(negedge clk);

    $display("Sent %0d request words under %0d partition-count settings (0..31).",
             words_sent, span_writes);
    $display("%0d allocations and %0d no-fit results seen, %0d faults.",
             fit_count, nofit_count, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("worst_fit_partition_allocator regression: pass");
    end else begin
      $display("worst_fit_partition_allocator regression: fail");
    end
    $finish;
  end

endmodule
